FILE: design/byte_append_buffer_with_search_core_defines.svh
// Assertion macros used by the checker file.
`ifndef BYTE_APPEND_BUFFER_WITH_SEARCH_CORE_DEFINES_SVH
`define BYTE_APPEND_BUFFER_WITH_SEARCH_CORE_DEFINES_SVH

// Assert a property on a named clock and active-low reset.
`define BAB_ASSERT_CK(lbl, ck, rst, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst) prop) \
	else $error("bab assertion failed");

// Assert a property on the block clock and reset.
`define BAB_ASSERT(lbl, prop) `BAB_ASSERT_CK(lbl, clk, arst_n, prop)

`endif

FILE: design/bab_pkg.sv
package bab_pkg;

	localparam int unsigned BAB_DEPTH = 64;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_READ   = 2'd1,
		ACT_FIND   = 2'd2,
		ACT_CLEAR  = 2'd3
	} act_t;

	// Search/read token that walks the cell chain
	typedef struct packed {
		logic       vld;
		logic       is_find;
		logic       ok;
		logic [7:0] key;
		logic [7:0] pos;
		logic [8:0] stop;
		logic       hit;
		logic [7:0] idx;
		logic [7:0] data;
	} tok_t;

	// Write/clear control broadcast to every cell
	typedef struct packed {
		logic       clr;
		logic       wr;
		logic [7:0] fill;
		logic [7:0] wdata;
	} cell_ctl_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] data_out;
		logic       found;
		logic [7:0] found_index;
		logic [7:0] fill_count;
	} res_t;

endpackage

FILE: design/bab_req_if.sv
interface bab_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic [7:0] position;
	logic [7:0] span_length;

	modport source (output valid, action, data_byte, position, span_length, input ready);
	modport sink (input valid, action, data_byte, position, span_length, output ready);
endinterface

FILE: design/bab_rsp_if.sv
interface bab_rsp_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [7:0] data_out;
	logic       found;
	logic [7:0] found_index;
	logic [7:0] fill_count;

	modport source (output valid, accepted, data_out, found, found_index, fill_count,
		input ready);
	modport sink (input valid, accepted, data_out, found, found_index, fill_count,
		output ready);
endinterface

FILE: design/bab_cell.sv
module bab_cell #(
	parameter logic [7:0] IDX = 8'd0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bab_pkg::cell_ctl_t ctl,
	input  bab_pkg::tok_t      tok_in,
	output bab_pkg::tok_t      tok_out
);
	import bab_pkg::*;

	logic [7:0] byte_q;
	tok_t       tok_q;
	tok_t       tok_nxt;
	logic       sel_find;
	logic       sel_rd;

	// Match the passing token against this cell's byte (find) or index (read)
	always_comb begin
		sel_find = tok_in.vld && tok_in.is_find && !tok_in.hit &&
			(tok_in.pos <= IDX) && ({1'b0, IDX} < tok_in.stop) &&
			(byte_q == tok_in.key);
		sel_rd = tok_in.vld && !tok_in.is_find && tok_in.ok && (tok_in.pos == IDX);
		tok_nxt = tok_in;
		if (sel_find) begin
			tok_nxt.hit  = 1'b1;
			tok_nxt.idx  = IDX;
			tok_nxt.data = byte_q;
		end
		if (sel_rd) begin
			tok_nxt.data = byte_q;
		end
	end

	// Hold the stored byte: clear wins over append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clr) begin
			byte_q <= '0;
		end else if (ctl.wr && (ctl.fill == IDX)) begin
			byte_q <= ctl.wdata;
		end
	end

	// Advance the token one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;
endmodule

FILE: design/byte_append_buffer_with_search_core.sv
// Channel | Modport | Moves
// req     | sink    | action, data_byte, position, span_length
// rsp     | source  | accepted, data_out, found, found_index, fill_count
//
// Append, clear and a rejected find go into the pending slot, then the output register.
// Read and accepted find walk the chain of DEPTH cells, one cell per cycle, into the slot.
// A new request is taken once no walk is in flight and the one-entry pending slot is empty.
// The slot empties into the output register while that register is free, so rsp may stall.
// Reset clears the fill count and all cells at once; no clearing pass.
module byte_append_buffer_with_search_core #(
	parameter int unsigned DEPTH = bab_pkg::BAB_DEPTH
) (
	input logic    clk,
	input logic    arst_n,
	bab_req_if.sink   req,
	bab_rsp_if.source rsp
);
	import bab_pkg::*;

	localparam logic [7:0] DEPTH_B = 8'(DEPTH);

	logic       accept;
	act_t       act;
	logic       has_room;
	logic [8:0] span_end;
	logic [7:0] fill_q;
	logic       walk_q;
	logic       pend_vld_q;
	logic       out_vld_q;
	res_t       pend_q;
	res_t       out_q;
	res_t       tok_res;
	tok_t       start_tok;
	cell_ctl_t  ctl;
	tok_t       tok_w [DEPTH+1];
	tok_t       last;

	assign accept   = req.valid && req.ready;
	assign act      = act_t'(req.action);
	assign has_room = fill_q < DEPTH_B;
	assign span_end = {1'b0, req.position} + {1'b0, req.span_length};
	assign req.ready = !walk_q && !pend_vld_q;

	// Build the token for read and in-range find
	always_comb begin
		start_tok         = '0;
		start_tok.vld     = accept && ((act == ACT_READ) ||
			((act == ACT_FIND) && (span_end <= {1'b0, fill_q})));
		start_tok.is_find = (act == ACT_FIND);
		start_tok.ok      = req.position < fill_q;
		start_tok.key     = req.data_byte;
		start_tok.pos     = req.position;
		start_tok.stop    = span_end;
	end

	// Broadcast append and clear to the cells
	always_comb begin
		ctl.clr   = accept && (act == ACT_CLEAR);
		ctl.wr    = accept && (act == ACT_APPEND) && has_room;
		ctl.fill  = fill_q;
		ctl.wdata = req.data_byte;
	end

	assign tok_w[0] = start_tok;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		bab_cell #(.IDX(8'(k))) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok_w[k]),
			.tok_out (tok_w[k+1])
		);
	end

	assign last = tok_w[DEPTH];

	// Turn the token leaving the chain into a result
	always_comb begin
		tok_res.accepted    = last.is_find;
		tok_res.data_out    = last.data;
		tok_res.found       = last.hit;
		tok_res.found_index = '0;
		if (last.is_find) begin
			tok_res.found_index = last.hit ? last.idx : 8'(last.stop - 9'd1);
		end
		tok_res.fill_count  = fill_q;
	end

	// Sequence requests, pending slot and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			walk_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			pend_q     <= '0;
			out_q      <= '0;
		end else begin
			// drain pending into the output register
			if (pend_vld_q && (!out_vld_q || rsp.ready)) begin
				out_q      <= pend_q;
				out_vld_q  <= 1'b1;
				pend_vld_q <= 1'b0;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			if (accept) begin
				unique case (act)
					ACT_APPEND: begin
						if (has_room) begin
							fill_q <= fill_q + 8'd1;
						end
						pend_q.accepted    <= has_room;
						pend_q.data_out    <= '0;
						pend_q.found       <= 1'b0;
						pend_q.found_index <= '0;
						pend_q.fill_count  <= has_room ? fill_q + 8'd1 : fill_q;
						pend_vld_q         <= 1'b1;
					end
					ACT_READ: begin
						walk_q <= 1'b1;
					end
					ACT_FIND: begin
						if (span_end > {1'b0, fill_q}) begin
							pend_q.accepted    <= 1'b0;
							pend_q.data_out    <= '0;
							pend_q.found       <= 1'b0;
							pend_q.found_index <= '0;
							pend_q.fill_count  <= fill_q;
							pend_vld_q         <= 1'b1;
						end else begin
							walk_q <= 1'b1;
						end
					end
					ACT_CLEAR: begin
						fill_q     <= '0;
						pend_q     <= '0;
						pend_vld_q <= 1'b1;
					end
					default: begin
						walk_q <= walk_q;
					end
				endcase
			end

			// capture the token at the end of the chain
			if (last.vld) begin
				walk_q     <= 1'b0;
				pend_q     <= tok_res;
				pend_vld_q <= 1'b1;
			end
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.accepted    = out_q.accepted;
	assign rsp.data_out    = out_q.data_out;
	assign rsp.found       = out_q.found;
	assign rsp.found_index = out_q.found_index;
	assign rsp.fill_count  = out_q.fill_count;
endmodule

FILE: design/bab_checker.sv
`include "byte_append_buffer_with_search_core_defines.svh"

module bab_checker #(
	parameter int unsigned DEPTH = bab_pkg::BAB_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       accepted,
	input logic [7:0] data_out,
	input logic       found,
	input logic [7:0] found_index,
	input logic [7:0] fill_count
);
	localparam logic [7:0] DEPTH_B = 8'(DEPTH);

	// Hold a stalled result
	`BAB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(found_index) && $stable(fill_count))
	// Fill never passes the store depth
	`BAB_ASSERT(a_fill_max, rsp_valid |-> fill_count <= DEPTH_B)
	// A hit only comes from an accepted search
	`BAB_ASSERT(a_found_acc, rsp_valid && found |-> accepted)
	// One request at a time: drop ready after each request
	`BAB_ASSERT(a_one_req, req_valid && req_ready |=> !req_ready)
endmodule

bind byte_append_buffer_with_search_core bab_checker #(.DEPTH(DEPTH)) u_bab_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.accepted    (rsp.accepted),
	.data_out    (rsp.data_out),
	.found       (rsp.found),
	.found_index (rsp.found_index),
	.fill_count  (rsp.fill_count)
);
